>>> design/cwp_pkg.sv
// shared types and constants for the window pooling block
package cwp_pkg;

  localparam int SampleBits = 16;
  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int MaxStep    = 8;
  localparam int PosBits    = 10;
  localparam int AccBits    = 40;
  localparam int CountBits  = 21;
  localparam int QueueDepth = 4;
  localparam int QueueBits  = 2;

  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegStep   = 2'd1;
  localparam logic [1:0] RegWidth  = 2'd2;
  localparam logic [1:0] RegHeight = 2'd3;

  typedef enum logic [2:0] {
    MODE_MAX  = 3'd0,
    MODE_AVG  = 3'd1,
    MODE_L2   = 3'd2,
    MODE_GMAX = 3'd3,
    MODE_GAVG = 3'd4
  } mode_t;

  // one classified pixel handed from the front to the back
  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic [PosBits-1:0]           col_idx;
    logic                         first;
    logic                         emit;
    logic                         last_pixel;
    logic [CountBits-1:0]         count;
  } work_t;

  typedef enum logic [2:0] {
    ST_ACC  = 3'd0,
    ST_READ = 3'd1,
    ST_UPD  = 3'd2,
    ST_DIV  = 3'd3,
    ST_SQRT = 3'd4,
    ST_OUT  = 3'd5
  } back_state_t;

endpackage

>>> design/cnn_window_pooling.sv
// top level of the window pooling block
// Pools a raster stream of signed Q8.8 samples over non-overlapping
// square windows (max, average, L2) or over the whole frame (global
// max, global average). Samples enter on s_axis (tdata = sample);
// results leave on m_axis (tdata = pooled, tlast = last result of frame).
// Registers must be written through cfg_we/cfg_index/cfg_data only while
// idle; the block does not enforce this. Any write restarts the frame at
// pixel (0,0). The front tracks position and classifies each sample in
// the cycle it is accepted, then hands it to a four-entry queue. The back
// takes each item through three steps (queue pop, column memory read,
// update) and pops no new item until the last one is done. An emitting
// item adds a restoring divide for average modes, plus a bitwise root
// for L2, then waits in the output register until the receiver takes
// it; meanwhile the front keeps accepting until the queue fills. Reset
// clears positions, the frame accumulator and the control state; the
// column memory needs no clearing since every window writes before it
// reads. Registers reset to max mode, step 2, 1024 x 1024.
module cnn_window_pooling (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] pooled
  output logic        m_axis_tlast
);

  logic [2:0]  reg_mode;
  logic [3:0]  reg_step;
  logic [10:0] reg_width, reg_height;
  cwp_pkg::mode_t mode;
  logic [3:0]  step;
  logic [10:0] width, height;
  logic push, full, pop, not_empty;
  cwp_pkg::work_t push_item, head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_mode <= cwp_pkg::MODE_MAX; reg_step <= 4'd2;
      reg_width <= 11'(cwp_pkg::MaxWidth); reg_height <= 11'(cwp_pkg::MaxHeight);
    end else if (cfg_we) begin
      case (cfg_index)
        cwp_pkg::RegMode:   reg_mode   <= cfg_data[2:0];
        cwp_pkg::RegStep:   reg_step   <= cfg_data[3:0];
        cwp_pkg::RegWidth:  reg_width  <= cfg_data;
        cwp_pkg::RegHeight: reg_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped settings
  always_comb begin
    mode   = (reg_mode > cwp_pkg::MODE_GAVG) ? cwp_pkg::MODE_MAX : cwp_pkg::mode_t'(reg_mode);
    step   = (reg_step == 4'd0) ? 4'd1 :
             (reg_step > 4'(cwp_pkg::MaxStep)) ? 4'(cwp_pkg::MaxStep) : reg_step;
    width  = (reg_width == 11'd0) ? 11'd1 :
             (reg_width > 11'(cwp_pkg::MaxWidth)) ? 11'(cwp_pkg::MaxWidth) : reg_width;
    height = (reg_height == 11'd0) ? 11'd1 :
             (reg_height > 11'(cwp_pkg::MaxHeight)) ? 11'(cwp_pkg::MaxHeight) : reg_height;
  end

  cwp_front u_front (
    .clk, .rst, .restart(cfg_we), .mode, .step, .width, .height,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_sample(s_axis_tdata),
    .push, .push_item, .queue_full(full)
  );

  cwp_queue u_queue (
    .clk, .rst, .push, .push_item, .full, .pop, .not_empty, .head
  );

  cwp_back u_back (
    .clk, .rst, .restart(cfg_we), .mode, .item_valid(not_empty), .item(head), .pop,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_pooled(m_axis_tdata), .out_last(m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty queue");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped while stalled");
`endif

endmodule

>>> design/cwp_front.sv
// front end: tracks pixel position and classifies each sample
module cwp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  cwp_pkg::mode_t                  mode,
  input  logic [3:0]                      step,
  input  logic [cwp_pkg::PosBits:0]       width,
  input  logic [cwp_pkg::PosBits:0]       height,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cwp_pkg::SampleBits-1:0]  in_sample,
  output logic                            push,
  output cwp_pkg::work_t                  push_item,
  input  logic                            queue_full
);

  logic [cwp_pkg::PosBits-1:0] col, row;
  logic [3:0] col_in, row_in;
  logic [cwp_pkg::PosBits-1:0] col_idx;
  logic [cwp_pkg::PosBits-1:0] col_base, row_base;
  logic [cwp_pkg::PosBits:0]   cols_left, rows_left;
  logic [3:0] cols, rows;
  logic last_col, last_row, whole_frame;

  assign in_ready    = !queue_full;
  assign push        = in_valid && in_ready;
  assign whole_frame = (mode == cwp_pkg::MODE_GMAX) || (mode == cwp_pkg::MODE_GAVG);
  assign last_col    = ({1'b0, col} == width - 1'b1);
  assign last_row    = ({1'b0, row} == height - 1'b1);

  // window-relative position, tracked by counters
  always_comb begin
    col_base  = col - cwp_pkg::PosBits'(col_in);
    row_base  = row - cwp_pkg::PosBits'(row_in);
    cols_left = width - {1'b0, col_base};
    rows_left = height - {1'b0, row_base};
    cols = (cols_left > {7'd0, step}) ? step : cols_left[3:0];
    rows = (rows_left > {7'd0, step}) ? step : rows_left[3:0];
  end

  // classified item
  always_comb begin
    push_item.sample     = $signed(in_sample);
    push_item.col_idx    = col_idx;
    push_item.last_pixel = last_col && last_row;
    if (whole_frame) begin
      push_item.first = (col == '0) && (row == '0);
      push_item.emit  = last_col && last_row;
      push_item.count = cwp_pkg::CountBits'(width) * cwp_pkg::CountBits'(height);
    end else begin
      push_item.first = (col_in == 4'd0) && (row_in == 4'd0);
      push_item.emit  = ((col_in == step - 4'd1) || last_col) &&
                        ((row_in == step - 4'd1) || last_row);
      push_item.count = cwp_pkg::CountBits'(cols) * cwp_pkg::CountBits'(rows);
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0; row <= '0; col_in <= '0; row_in <= '0; col_idx <= '0;
    end else if (push) begin
      if (last_col) begin
        col <= '0; col_in <= '0; col_idx <= '0;
        if (last_row) begin
          row <= '0; row_in <= '0;
        end else begin
          row    <= row + 1'b1;
          row_in <= (row_in == step - 4'd1) ? 4'd0 : row_in + 4'd1;
        end
      end else begin
        col <= col + 1'b1;
        if (col_in == step - 4'd1) begin
          col_in  <= '0;
          col_idx <= col_idx + 1'b1;
        end else begin
          col_in <= col_in + 4'd1;
        end
      end
    end
  end

endmodule

>>> design/cwp_queue.sv
// small fifo between front and back
module cwp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cwp_pkg::work_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output cwp_pkg::work_t head
);

  cwp_pkg::work_t slots [cwp_pkg::QueueDepth];
  logic [cwp_pkg::QueueBits-1:0] wr_ptr, rd_ptr;
  logic [cwp_pkg::QueueBits:0]   fill;

  assign full      = (fill == (cwp_pkg::QueueBits+1)'(cwp_pkg::QueueDepth));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (cwp_pkg::QueueBits+1)'(push) - (cwp_pkg::QueueBits+1)'(pop);
    end
  end

endmodule

>>> design/cwp_back.sv
// back end: accumulates windows, divides, takes roots, drives results
module cwp_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  cwp_pkg::mode_t                  mode,
  input  logic                            item_valid,
  input  cwp_pkg::work_t                  item,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cwp_pkg::SampleBits-1:0]  out_pooled,
  output logic                            out_last
);

  localparam int AB = cwp_pkg::AccBits;

  cwp_pkg::back_state_t state, state_next;
  logic signed [AB-1:0] col_mem [cwp_pkg::MaxWidth];
  logic signed [AB-1:0] rd_data, frame_acc, acc, acc_new;
  logic signed [2*cwp_pkg::SampleBits-1:0] term;
  cwp_pkg::work_t cur;
  logic whole_frame;

  // divider and root registers
  logic [AB-1:0] quot, rem_val, dividend;
  logic          neg;
  logic [5:0]    cnt;
  logic [AB-1:0] sq_v, sq_root, sq_bit;
  logic [AB:0]   rem_try;
  logic [AB-1:0] sq_try;

  assign whole_frame = (mode == cwp_pkg::MODE_GMAX) || (mode == cwp_pkg::MODE_GAVG);
  assign term   = (mode == cwp_pkg::MODE_L2) ? cur.sample * cur.sample
                                              : 32'(signed'(cur.sample));
  assign pop    = (state == cwp_pkg::ST_ACC) && item_valid;
  assign out_valid = (state == cwp_pkg::ST_OUT);
  assign acc = whole_frame ? frame_acc : rd_data;

  // new accumulator value
  always_comb begin
    if (cur.first) acc_new = AB'(term);
    else if (mode == cwp_pkg::MODE_MAX || mode == cwp_pkg::MODE_GMAX ||
             mode > cwp_pkg::MODE_GAVG)
      acc_new = (AB'(term) > acc) ? AB'(term) : acc;
    else acc_new = acc + AB'(term);
  end

  assign rem_try = {rem_val, quot[AB-1]} - {1'b0, AB'(cur.count)};
  assign sq_try  = sq_root + sq_bit;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      cwp_pkg::ST_ACC:  if (item_valid) state_next = cwp_pkg::ST_READ;
      cwp_pkg::ST_READ: state_next = cwp_pkg::ST_UPD;
      cwp_pkg::ST_UPD: begin
        if (!cur.emit) state_next = cwp_pkg::ST_ACC;
        else if (mode == cwp_pkg::MODE_AVG || mode == cwp_pkg::MODE_L2 ||
                 mode == cwp_pkg::MODE_GAVG) state_next = cwp_pkg::ST_DIV;
        else state_next = cwp_pkg::ST_OUT;
      end
      cwp_pkg::ST_DIV:
        if (cnt == 6'd0)
          state_next = (mode == cwp_pkg::MODE_L2) ? cwp_pkg::ST_SQRT : cwp_pkg::ST_OUT;
      cwp_pkg::ST_SQRT: if (sq_bit == '0) state_next = cwp_pkg::ST_OUT;
      cwp_pkg::ST_OUT:  if (out_ready) state_next = cwp_pkg::ST_ACC;
      default: state_next = cwp_pkg::ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cwp_pkg::ST_ACC;
    else state <= state_next;
  end

  // column accumulator memory
  always_ff @(posedge clk) begin
    if (state == cwp_pkg::ST_READ) rd_data <= col_mem[cur.col_idx];
    if (state == cwp_pkg::ST_UPD && !whole_frame) col_mem[cur.col_idx] <= acc_new;
  end

  // frame accumulator
  always_ff @(posedge clk) begin
    if (rst || restart) frame_acc <= '0;
    else if (state == cwp_pkg::ST_UPD && whole_frame) frame_acc <= acc_new;
  end

  // datapath: restoring divide by count for average and L2 modes, then bitwise root for L2, then saturate
  always_ff @(posedge clk) begin
    case (state)
      cwp_pkg::ST_ACC: if (pop) cur <= item;
      cwp_pkg::ST_UPD: begin
        neg      <= acc_new[AB-1];
        quot     <= acc_new[AB-1] ? -acc_new : acc_new;
        rem_val  <= '0;
        cnt      <= 6'(AB);
        dividend <= acc_new;
      end
      cwp_pkg::ST_DIV: begin
        if (cnt != 6'd0) begin
          cnt <= cnt - 6'd1;
          if (!rem_try[AB]) begin
            rem_val <= rem_try[AB-1:0];
            quot    <= {quot[AB-2:0], 1'b1};
          end else begin
            rem_val <= {rem_val[AB-2:0], quot[AB-1]};
            quot    <= {quot[AB-2:0], 1'b0};
          end
        end else begin
          dividend <= neg ? -quot : quot;
          sq_v     <= quot;
          sq_root  <= '0;
          sq_bit   <= AB'(1) << (AB-2);
        end
      end
      cwp_pkg::ST_SQRT: begin
        if (sq_bit != '0) begin
          if (sq_v >= sq_try) begin
            sq_v    <= sq_v - sq_try;
            sq_root <= (sq_root >> 1) + sq_bit;
          end else begin
            sq_root <= sq_root >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end else begin
          dividend <= sq_root;
        end
      end
      default: ;
    endcase
  end

  // saturated result
  always_comb begin
    if ($signed(dividend) > 40'sd32767) out_pooled = 16'h7FFF;
    else if ($signed(dividend) < -40'sd32768) out_pooled = 16'h8000;
    else out_pooled = dividend[15:0];
  end
  assign out_last = cur.last_pixel;

endmodule
